// File: hw/rtl/planar_three_link_forward_kinematics_unit_macros.svh
// Assertion macros shared by the forward kinematics RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PLANAR_THREE_LINK_FORWARD_KINEMATICS_UNIT_MACROS_SVH
`define PLANAR_THREE_LINK_FORWARD_KINEMATICS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define P3FK_ASSERT_IMPLIES(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Delayed implication, with the delay given by argument n, disabled while reset is asserted.
`define P3FK_ASSERT_LATENCY(label, clk, rst_n, trig, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> ##n (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/p3fk_pkg.sv
// Shared types and constants of the planar three-link forward kinematics unit.
// No dependencies; imported by every module of the block.
package p3fk_pkg;

    // CORDIC geometry: 30 rotations on a 32-bit turn, Q1.30 results.
    localparam int CORDIC_STEPS = 30;
    localparam int TURN_BITS    = 32;
    localparam int CORDIC_W     = 34;
    localparam int FRAC_SHIFT   = 30;
    localparam int LANES        = 3;

    typedef logic signed [CORDIC_W-1:0] p3fk_word_t;

    // Start vector length: the CORDIC gain reciprocal in Q1.30.
    localparam p3fk_word_t CORDIC_GAIN = 34'sh026DD3B6A;

    // Rotation vector and residual angle of one lane.
    typedef struct packed {
        p3fk_word_t x;
        p3fk_word_t y;
        p3fk_word_t z;
    } p3fk_rot_t;

    // Control that travels along the rotation pipeline.
    typedef struct packed {
        logic             valid;
        logic [LANES-1:0] flip;
    } p3fk_ctl_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_LINK1 = 2'd0,
        REG_LINK2 = 2'd1,
        REG_LINK3 = 2'd2
    } p3fk_reg_t;

    // Arctangent of 2^-step, in units of 2^-32 turn.
    function automatic p3fk_word_t atan_turn(input logic [4:0] step);
        p3fk_word_t a;
        case (step)
            5'd0:    a = 34'sh020000000;
            5'd1:    a = 34'sh012E4051E;
            5'd2:    a = 34'sh009FB385B;
            5'd3:    a = 34'sh0051111D4;
            5'd4:    a = 34'sh0028B0D43;
            5'd5:    a = 34'sh00145D7E1;
            5'd6:    a = 34'sh000A2F61E;
            5'd7:    a = 34'sh000517C55;
            5'd8:    a = 34'sh00028BE53;
            5'd9:    a = 34'sh000145F2F;
            5'd10:   a = 34'sh0000A2F98;
            5'd11:   a = 34'sh0000517CC;
            5'd12:   a = 34'sh000028BE6;
            5'd13:   a = 34'sh0000145F3;
            5'd14:   a = 34'sh00000A2FA;
            5'd15:   a = 34'sh00000517D;
            5'd16:   a = 34'sh0000028BE;
            5'd17:   a = 34'sh00000145F;
            5'd18:   a = 34'sh000000A30;
            5'd19:   a = 34'sh000000518;
            5'd20:   a = 34'sh00000028C;
            5'd21:   a = 34'sh000000146;
            5'd22:   a = 34'sh0000000A3;
            5'd23:   a = 34'sh000000051;
            5'd24:   a = 34'sh000000029;
            5'd25:   a = 34'sh000000014;
            5'd26:   a = 34'sh00000000A;
            5'd27:   a = 34'sh000000005;
            5'd28:   a = 34'sh000000003;
            5'd29:   a = 34'sh000000001;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: hw/rtl/p3fk_angle_prep.sv
// Input stage: running joint angle sums, heading and CORDIC start vectors.
// Depends on p3fk_pkg and the shared assertion macros.
`include "planar_three_link_forward_kinematics_unit_macros.svh"

module p3fk_angle_prep
    import p3fk_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic signed [ANGLE_BITS-1:0]  joint1_angle,
    input  logic signed [ANGLE_BITS-1:0]  joint2_angle,
    input  logic signed [ANGLE_BITS-1:0]  joint3_angle,
    output p3fk_ctl_t                     ctl_out,
    output p3fk_rot_t [LANES-1:0]         rot_out,
    output logic signed [ANGLE_BITS+1:0]  heading_out
);

    localparam int PAD_BITS = TURN_BITS - ANGLE_BITS;
    localparam int HEAD_W   = ANGLE_BITS + 2;

    logic [LANES-1:0][ANGLE_BITS-1:0] wrapped;
    logic [LANES-1:0]                 flip_next;
    p3fk_rot_t [LANES-1:0]            rot_next;
    logic signed [HEAD_W-1:0]         heading_next;

    logic                             valid_reg;
    logic [LANES-1:0]                 flip_reg;
    p3fk_rot_t [LANES-1:0]            rot_reg;
    logic signed [HEAD_W-1:0]         heading_reg;

    // Running sums wrap modulo a full turn; the heading keeps all bits.
    always_comb
    begin
        wrapped[0]   = joint1_angle;
        wrapped[1]   = joint1_angle + joint2_angle;
        wrapped[2]   = joint1_angle + joint2_angle + joint3_angle;
        heading_next = HEAD_W'(joint1_angle) + HEAD_W'(joint2_angle) + HEAD_W'(joint3_angle);
    end

    // Scale each angle to a 32-bit turn and fold the left half-plane onto the right.
    always_comb
    begin
        logic [TURN_BITS-1:0] turn;
        for (int k = 0; k < LANES; k++)
        begin
            turn                 = {wrapped[k], {PAD_BITS{1'b0}}};
            flip_next[k]         = turn[TURN_BITS-1] ^ turn[TURN_BITS-2];
            turn[TURN_BITS-1]    = turn[TURN_BITS-1] ^ flip_next[k];
            rot_next[k].x        = CORDIC_GAIN;
            rot_next[k].y        = '0;
            rot_next[k].z        = {{(CORDIC_W-TURN_BITS){turn[TURN_BITS-1]}}, turn};
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= take;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        flip_reg    <= flip_next;
        rot_reg     <= rot_next;
        heading_reg <= heading_next;
    end

    assign ctl_out.valid = valid_reg;
    assign ctl_out.flip  = flip_reg;
    assign rot_out       = rot_reg;
    assign heading_out   = heading_reg;

    // After folding, every residual angle lies within a quarter turn of zero.
    `P3FK_ASSERT_IMPLIES(a_prep_half_plane, clk, rst_n, valid_reg, (rot_reg[0].z[TURN_BITS-1] == rot_reg[0].z[TURN_BITS-2]) && (rot_reg[1].z[TURN_BITS-1] == rot_reg[1].z[TURN_BITS-2]) && (rot_reg[2].z[TURN_BITS-1] == rot_reg[2].z[TURN_BITS-2]), "prep: folded angle outside the right half-plane")

endmodule

// File: hw/rtl/p3fk_cordic_stage.sv
// One registered CORDIC rotation step, applied to all three angle lanes.
// Depends on p3fk_pkg for the word type and the arctangent table.
module p3fk_cordic_stage
    import p3fk_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  p3fk_ctl_t             ctl_in,
    input  p3fk_rot_t [LANES-1:0] rot_in,
    output p3fk_ctl_t             ctl_out,
    output p3fk_rot_t [LANES-1:0] rot_out
);

    localparam p3fk_word_t ATAN = atan_turn(5'(STAGE));

    p3fk_rot_t [LANES-1:0] rot_next;
    p3fk_rot_t [LANES-1:0] rot_reg;
    logic                  valid_reg;
    logic [LANES-1:0]      flip_reg;

    // Rotate toward a zero residual; arithmetic shifts round toward minus infinity.
    always_comb
    begin
        p3fk_word_t dx;
        p3fk_word_t dy;
        for (int k = 0; k < LANES; k++)
        begin
            dx = rot_in[k].y >>> STAGE;
            dy = rot_in[k].x >>> STAGE;
            if (!rot_in[k].z[CORDIC_W-1])
            begin
                rot_next[k].x = rot_in[k].x - dx;
                rot_next[k].y = rot_in[k].y + dy;
                rot_next[k].z = rot_in[k].z - ATAN;
            end
            else
            begin
                rot_next[k].x = rot_in[k].x + dx;
                rot_next[k].y = rot_in[k].y - dy;
                rot_next[k].z = rot_in[k].z + ATAN;
            end
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        flip_reg <= ctl_in.flip;
        rot_reg  <= rot_next;
    end

    assign ctl_out.valid = valid_reg;
    assign ctl_out.flip  = flip_reg;
    assign rot_out       = rot_reg;

endmodule

// File: hw/rtl/p3fk_combine.sv
// Output pipeline: unfold, scale by link lengths, sum, round and clamp.
// Depends on p3fk_pkg and the shared assertion macros.
`include "planar_three_link_forward_kinematics_unit_macros.svh"

module p3fk_combine
    import p3fk_pkg::*;
#(
    parameter int ANGLE_BITS       = 16,
    parameter int LENGTH_FRAC_BITS = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  p3fk_ctl_t                               ctl_in,
    input  p3fk_rot_t [LANES-1:0]                   rot_in,
    input  logic signed [ANGLE_BITS+1:0]            heading_in,
    input  logic [LANES-1:0][LENGTH_FRAC_BITS-1:0]  link_length,
    output logic                                    done,
    output logic signed [LENGTH_FRAC_BITS+2:0]      pos_x,
    output logic signed [LENGTH_FRAC_BITS+2:0]      pos_y,
    output logic signed [ANGLE_BITS+1:0]            heading
);

    localparam int LEN_S_W = LENGTH_FRAC_BITS + 1;
    localparam int PROD_W  = LEN_S_W + CORDIC_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int RND_W   = SUM_W - FRAC_SHIFT;
    localparam int POS_W   = LENGTH_FRAC_BITS + 3;
    localparam int HEAD_W  = ANGLE_BITS + 2;

    localparam logic signed [SUM_W-1:0]    ROUND_BIAS = SUM_W'(1) << (FRAC_SHIFT - 1);
    localparam logic signed [RND_W-1:0]    POS_LIMIT  = RND_W'(3) << LENGTH_FRAC_BITS;
    localparam logic signed [RND_W-1:0]    NEG_LIMIT  = -POS_LIMIT;
    localparam p3fk_word_t                 TRIG_BOUND = 34'sh040000400;

    // Unfold stage.
    logic                        f_valid_reg;
    p3fk_word_t                  cos_reg [LANES];
    p3fk_word_t                  sin_reg [LANES];
    logic signed [HEAD_W-1:0]    f_head_reg;

    // Multiply stage.
    logic                        m_valid_reg;
    logic signed [PROD_W-1:0]    prod_x_reg [LANES];
    logic signed [PROD_W-1:0]    prod_y_reg [LANES];
    logic signed [HEAD_W-1:0]    m_head_reg;
    logic signed [LEN_S_W-1:0]   len_s [LANES];

    // Sum stage.
    logic                        s_valid_reg;
    logic signed [SUM_W-1:0]     sum_x_reg;
    logic signed [SUM_W-1:0]     sum_y_reg;
    logic signed [HEAD_W-1:0]    s_head_reg;

    // Output stage.
    logic                        done_reg;
    logic signed [RND_W-1:0]     rnd_x;
    logic signed [RND_W-1:0]     rnd_y;
    logic signed [POS_W-1:0]     pos_x_next;
    logic signed [POS_W-1:0]     pos_y_next;
    logic signed [POS_W-1:0]     pos_x_reg;
    logic signed [POS_W-1:0]     pos_y_reg;
    logic signed [HEAD_W-1:0]    heading_reg;

    logic                        trig_ok;

    function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [RND_W-1:0] v);
        logic signed [RND_W-1:0] c;
        if (v > POS_LIMIT)
        begin
            c = POS_LIMIT;
        end
        else if (v < NEG_LIMIT)
        begin
            c = NEG_LIMIT;
        end
        else
        begin
            c = v;
        end
        return POS_W'(c);
    endfunction

    // Link lengths as non-negative signed multiplicands.
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            len_s[k] = {1'b0, link_length[k]};
        end
    end

    // Drop the fraction with round half up, then saturate to three metres.
    always_comb
    begin
        rnd_x      = sum_x_reg[SUM_W-1:FRAC_SHIFT];
        rnd_y      = sum_y_reg[SUM_W-1:FRAC_SHIFT];
        pos_x_next = clamp_pos(rnd_x);
        pos_y_next = clamp_pos(rnd_y);
    end

    // Valid bits of the four stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            f_valid_reg <= ctl_in.valid;
            m_valid_reg <= f_valid_reg;
            s_valid_reg <= m_valid_reg;
            done_reg    <= s_valid_reg;
        end
    end

    // Payload: unfold, products, sums, final values.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LANES; k++)
        begin
            cos_reg[k]    <= ctl_in.flip[k] ? -rot_in[k].x : rot_in[k].x;
            sin_reg[k]    <= ctl_in.flip[k] ? -rot_in[k].y : rot_in[k].y;
            prod_x_reg[k] <= len_s[k] * cos_reg[k];
            prod_y_reg[k] <= len_s[k] * sin_reg[k];
        end
        sum_x_reg   <= SUM_W'(prod_x_reg[0]) + SUM_W'(prod_x_reg[1]) + SUM_W'(prod_x_reg[2])
                       + ROUND_BIAS;
        sum_y_reg   <= SUM_W'(prod_y_reg[0]) + SUM_W'(prod_y_reg[1]) + SUM_W'(prod_y_reg[2])
                       + ROUND_BIAS;
        pos_x_reg   <= pos_x_next;
        pos_y_reg   <= pos_y_next;
        f_head_reg  <= heading_in;
        m_head_reg  <= f_head_reg;
        s_head_reg  <= m_head_reg;
        heading_reg <= s_head_reg;
    end

    // Sine and cosine magnitudes stay near one.
    always_comb
    begin
        trig_ok = 1'b1;
        for (int k = 0; k < LANES; k++)
        begin
            if (cos_reg[k] > TRIG_BOUND || cos_reg[k] < -TRIG_BOUND ||
                sin_reg[k] > TRIG_BOUND || sin_reg[k] < -TRIG_BOUND)
            begin
                trig_ok = 1'b0;
            end
        end
    end

    assign done    = done_reg;
    assign pos_x   = pos_x_reg;
    assign pos_y   = pos_y_reg;
    assign heading = heading_reg;

    `P3FK_ASSERT_IMPLIES(a_comb_trig_range, clk, rst_n, f_valid_reg, trig_ok, "combine: CORDIC output magnitude out of range")
    `P3FK_ASSERT_IMPLIES(a_comb_pos_range, clk, rst_n, done_reg, (pos_x_reg <= POS_LIMIT) && (pos_x_reg >= NEG_LIMIT) && (pos_y_reg <= POS_LIMIT) && (pos_y_reg >= NEG_LIMIT), "combine: position outside the clamp range")

endmodule

// File: hw/rtl/planar_three_link_forward_kinematics_unit.sv
// Top level of the planar three-link forward kinematics unit.
// Depends on p3fk_pkg, p3fk_angle_prep, p3fk_cordic_stage, p3fk_combine and the macros.
`include "planar_three_link_forward_kinematics_unit_macros.svh"

// Usage:
// A request (three joint angles) is taken at each rising edge with start high
// and busy low. busy stays low: the pipeline takes a new request every cycle.
// Each request returns exactly one result (pos_x, pos_y, heading), shown for
// one cycle with done high, in request order. Throughput is one result per
// cycle. A request passes through the input stage, thirty CORDIC rotation
// stages (one per rotation, three angle lanes side by side) and four output
// stages (unfold, multiply, sum, round/clamp).
// The receiver cannot stall; results must be captured when done is high.
// Link lengths are written through wr_en/wr_index/wr_data with no wait;
// write them only while no request is in flight. An index of 3 is ignored.
// Reset (rst_n low, asynchronous) clears all valid bits, dropping requests
// in flight, and loads the link lengths 0.30 m, 0.20 m and 0.15 m.
module planar_three_link_forward_kinematics_unit
    import p3fk_pkg::*;
#(
    parameter int ANGLE_BITS       = 16,
    parameter int LENGTH_FRAC_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [ANGLE_BITS-1:0]        joint1_angle,
    input  logic signed [ANGLE_BITS-1:0]        joint2_angle,
    input  logic signed [ANGLE_BITS-1:0]        joint3_angle,
    output logic                                done,
    output logic signed [LENGTH_FRAC_BITS+2:0]  pos_x,
    output logic signed [LENGTH_FRAC_BITS+2:0]  pos_y,
    output logic signed [ANGLE_BITS+1:0]        heading,
    input  logic                                wr_en,
    input  logic [1:0]                          wr_index,
    input  logic [LENGTH_FRAC_BITS-1:0]         wr_data
);

    localparam int LATENCY = CORDIC_STEPS + 5;
    localparam int HEAD_W  = ANGLE_BITS + 2;

    localparam logic [LENGTH_FRAC_BITS-1:0] LINK1_RESET =
        LENGTH_FRAC_BITS'(((longint'(1) << LENGTH_FRAC_BITS) * 3 + 5) / 10);
    localparam logic [LENGTH_FRAC_BITS-1:0] LINK2_RESET =
        LENGTH_FRAC_BITS'(((longint'(1) << LENGTH_FRAC_BITS) * 2 + 5) / 10);
    localparam logic [LENGTH_FRAC_BITS-1:0] LINK3_RESET =
        LENGTH_FRAC_BITS'(((longint'(1) << LENGTH_FRAC_BITS) * 15 + 50) / 100);

    logic                                  take;
    logic [LENGTH_FRAC_BITS-1:0]           link1_reg;
    logic [LENGTH_FRAC_BITS-1:0]           link2_reg;
    logic [LENGTH_FRAC_BITS-1:0]           link3_reg;
    logic [LANES-1:0][LENGTH_FRAC_BITS-1:0] link_length;

    p3fk_ctl_t                             ctl_chain [CORDIC_STEPS+1];
    p3fk_rot_t [LANES-1:0]                 rot_chain [CORDIC_STEPS+1];
    logic signed [HEAD_W-1:0]              prep_heading;
    logic signed [HEAD_W-1:0]              head_line_reg [CORDIC_STEPS];

    // The pipeline never holds a request off.
    assign busy = 1'b0;
    assign take = start && !busy;

    // Link length registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link1_reg <= LINK1_RESET;
            link2_reg <= LINK2_RESET;
            link3_reg <= LINK3_RESET;
        end
        else if (wr_en)
        begin
            case (p3fk_reg_t'(wr_index))
                REG_LINK1: link1_reg <= wr_data;
                REG_LINK2: link2_reg <= wr_data;
                REG_LINK3: link3_reg <= wr_data;
                default:   ;
            endcase
        end
    end

    assign link_length[0] = link1_reg;
    assign link_length[1] = link2_reg;
    assign link_length[2] = link3_reg;

    // Angle sums and start vectors.
    p3fk_angle_prep #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .joint1_angle (joint1_angle),
        .joint2_angle (joint2_angle),
        .joint3_angle (joint3_angle),
        .ctl_out      (ctl_chain[0]),
        .rot_out      (rot_chain[0]),
        .heading_out  (prep_heading)
    );

    // Rotation pipeline, one step per stage.
    for (genvar s = 0; s < CORDIC_STEPS; s++)
    begin : g_rot
        p3fk_cordic_stage #(
            .STAGE (s)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_chain[s]),
            .rot_in  (rot_chain[s]),
            .ctl_out (ctl_chain[s+1]),
            .rot_out (rot_chain[s+1])
        );
    end

    // Heading rides alongside the rotation pipeline.
    always_ff @(posedge clk)
    begin
        head_line_reg[0] <= prep_heading;
        for (int s = 1; s < CORDIC_STEPS; s++)
        begin
            head_line_reg[s] <= head_line_reg[s-1];
        end
    end

    // Scale, sum, round and clamp.
    p3fk_combine #(
        .ANGLE_BITS       (ANGLE_BITS),
        .LENGTH_FRAC_BITS (LENGTH_FRAC_BITS)
    ) u_combine (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_in      (ctl_chain[CORDIC_STEPS]),
        .rot_in      (rot_chain[CORDIC_STEPS]),
        .heading_in  (head_line_reg[CORDIC_STEPS-1]),
        .link_length (link_length),
        .done        (done),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading     (heading)
    );

    // Every request yields one result after a fixed latency, and nothing else does.
    `P3FK_ASSERT_LATENCY(a_top_result_follows, clk, rst_n, take, LATENCY, done, "top: request produced no result at the expected cycle")
    `P3FK_ASSERT_IMPLIES(a_top_result_has_request, clk, rst_n, done, $past(take, LATENCY), "top: result without a matching request")

endmodule

// File: tb/sv/testbench.sv
// Testbench for the planar three-link forward kinematics unit: directed joint table, then
// random joint triples under several link-length settings, all checked against a predictor.
// Depends on p3fk_pkg and planar_three_link_forward_kinematics_unit.
`timescale 1ns / 1ps

module testbench;
    import p3fk_pkg::*;

    localparam int ANG_W  = 16;
    localparam int LEN_W  = 16;
    localparam int POS_W  = LEN_W + 3;
    localparam int HEAD_W = ANG_W + 2;

    localparam longint ROT_GAIN  = 64'sh26DD3B6A;
    localparam longint POS_LIMIT = 64'sd3 <<< LEN_W;
    localparam int     ROT_STEPS = 30;
    localparam int     DIR_ROWS  = 20;
    localparam int     PHASES    = 6;
    localparam int     PHASE_REQ = 125;
    localparam int     SETTLE    = 40;

    // Register index that the block must ignore.
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef logic signed [ANG_W-1:0]  joint_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [HEAD_W-1:0] head_t;

    typedef struct packed {
        pos_t  pos_x;
        pos_t  pos_y;
        head_t heading;
    } pose_t;

    typedef struct packed {
        joint_t j1;
        joint_t j2;
        joint_t j3;
        logic   head_known;
        head_t  head;
    } joint_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    joint_t           joint1_angle;
    joint_t           joint2_angle;
    joint_t           joint3_angle;
    logic             done;
    pos_t             pos_x;
    pos_t             pos_y;
    head_t            heading;
    logic             wr_en;
    logic [1:0]       wr_index;
    logic [LEN_W-1:0] wr_data;

    // Predictor copy of the link length registers.
    logic [LEN_W-1:0] link_len [3];

    pose_t expected_poses [$];
    int    mismatches;

    planar_three_link_forward_kinematics_unit #(
        .ANGLE_BITS       (ANG_W),
        .LENGTH_FRAC_BITS (LEN_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .joint1_angle (joint1_angle),
        .joint2_angle (joint2_angle),
        .joint3_angle (joint3_angle),
        .done         (done),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .heading      (heading),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    // Clock, 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic longint arctan_turn(input int i);
        case (i)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            15: return 64'h0000517D;
            16: return 64'h000028BE;
            17: return 64'h0000145F;
            18: return 64'h00000A30;
            19: return 64'h00000518;
            20: return 64'h0000028C;
            21: return 64'h00000146;
            22: return 64'h000000A3;
            23: return 64'h00000051;
            24: return 64'h00000029;
            25: return 64'h00000014;
            26: return 64'h0000000A;
            27: return 64'h00000005;
            28: return 64'h00000003;
            29: return 64'h00000001;
            default: return 64'h0;
        endcase
    endfunction

    // Rotation-mode CORDIC: cosine and sine in Q1.30 of a wrapped joint angle.
    function automatic void rotate_unit(input logic [ANG_W-1:0] ang,
                                        output longint cos_q, output longint sin_q);
        logic [31:0] turn;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        int          i;
        turn = {ang, {(32 - ANG_W){1'b0}}};
        flip = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
        if (flip)
            turn = turn + 32'h8000_0000;
        z = longint'($signed(turn));
        x = ROT_GAIN;
        y = 0;
        for (i = 0; i < ROT_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_turn(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_turn(i);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cos_q = x;
        sin_q = y;
    endfunction

    // Round half up out of Q.30 and clamp to the position range.
    function automatic pos_t round_clamp(input longint acc);
        longint r;
        r = (acc + (64'sd1 <<< 29)) >>> 30;
        if (r > POS_LIMIT)
            r = POS_LIMIT;
        if (r < -POS_LIMIT)
            r = -POS_LIMIT;
        return pos_t'(r);
    endfunction

    // End effector pose for one joint triple under the current link lengths.
    function automatic pose_t predict_pose(input joint_t j1, input joint_t j2, input joint_t j3);
        logic [ANG_W-1:0] sum2;
        logic [ANG_W-1:0] sum3;
        longint           c1, s1, c2, s2, c3, s3;
        longint           acc_x;
        longint           acc_y;
        pose_t            p;
        sum2 = j1 + j2;
        sum3 = j1 + j2 + j3;
        rotate_unit(j1, c1, s1);
        rotate_unit(sum2, c2, s2);
        rotate_unit(sum3, c3, s3);
        acc_x = longint'(link_len[0]) * c1 + longint'(link_len[1]) * c2
              + longint'(link_len[2]) * c3;
        acc_y = longint'(link_len[0]) * s1 + longint'(link_len[1]) * s2
              + longint'(link_len[2]) * s3;
        p.pos_x   = round_clamp(acc_x);
        p.pos_y   = round_clamp(acc_y);
        p.heading = j1 + j2 + j3;
        return p;
    endfunction

    function automatic joint_row_t make_row(input int a, input int b, input int c,
                                            input bit known, input int h);
        joint_row_t r;
        r.j1         = joint_t'(a);
        r.j2         = joint_t'(b);
        r.j3         = joint_t'(c);
        r.head_known = known;
        r.head       = head_t'(h);
        return r;
    endfunction

    // Directed joint table: extremes, quadrant edges, wrap of the running sums.
    function automatic joint_row_t directed_row(input int k);
        case (k)
            0:  return make_row(0, 0, 0, 1, 0);
            1:  return make_row(32767, 32767, 32767, 1, 98301);
            2:  return make_row(-32768, -32768, -32768, 1, -98304);
            3:  return make_row(32767, -32768, 0, 1, -1);
            4:  return make_row(16384, 0, 0, 1, 16384);
            5:  return make_row(16383, 0, 0, 1, 16383);
            6:  return make_row(-16384, 0, 0, 1, -16384);
            7:  return make_row(-16385, 0, 0, 1, -16385);
            8:  return make_row(-32768, 0, 0, 1, -32768);
            9:  return make_row(16384, 16384, 0, 1, 32768);
            10: return make_row(32767, 1, 0, 1, 32768);
            11: return make_row(1, -1, 1, 1, 1);
            12: return make_row(-1, -1, -1, 1, -3);
            13: return make_row(8192, 8192, 8192, 1, 24576);
            14: return make_row(12345, -23456, 30000, 0, 0);
            15: return make_row(-20000, -20000, -20000, 1, -60000);
            16: return make_row(24576, 24576, 24576, 1, 73728);
            17: return make_row(32767, 32767, -32768, 1, 32766);
            18: return make_row(21845, -21846, 21845, 1, 21844);
            default: return make_row(-21846, 21845, -21846, 1, -21847);
        endcase
    endfunction

    // Random joint angle, biased towards extremes, quadrant edges and small values.
    function automatic joint_t pick_angle();
        int base;
        case ($urandom_range(0, 5))
            0, 1, 2: return joint_t'($urandom);
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       return joint_t'(-32768);
                    1:       return joint_t'(32767);
                    2:       return joint_t'(-1);
                    3:       return joint_t'(1);
                    default: return joint_t'(0);
                endcase
            end
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       base = 16384;
                    1:       base = -16384;
                    2:       base = -32768;
                    default: base = 0;
                endcase
                return joint_t'(base + int'($urandom_range(0, 6)) - 3);
            end
            default: return joint_t'(int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    // Issue one request and hold it until the block takes it.
    task automatic send_request(input joint_t j1, input joint_t j2, input joint_t j3,
                                input bit head_known, input head_t head);
        pose_t want;
        start        <= 1'b1;
        joint1_angle <= j1;
        joint2_angle <= j2;
        joint3_angle <= j3;
        want = predict_pose(j1, j2, j3);
        if (head_known)
            want.heading = head;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        expected_poses.push_back(want);
    endtask

    // Leave the request side idle, with junk on the angle inputs.
    task automatic rest(input int cycles);
        start        <= 1'b0;
        joint1_angle <= joint_t'($urandom);
        joint2_angle <= joint_t'($urandom);
        joint3_angle <= joint_t'($urandom);
        repeat (cycles)
            @(posedge clk);
    endtask

    // Stop issuing and wait until every outstanding pose has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (expected_poses.size() != 0)
            @(posedge clk);
    endtask

    // Write all three link lengths, plus a write to the unused index.
    task automatic set_links(input logic [LEN_W-1:0] l1, input logic [LEN_W-1:0] l2,
                             input logic [LEN_W-1:0] l3);
        wr_en    <= 1'b1;
        wr_index <= REG_LINK1;
        wr_data  <= l1;
        @(posedge clk);
        wr_index <= REG_LINK2;
        wr_data  <= l2;
        @(posedge clk);
        wr_index <= REG_LINK3;
        wr_data  <= l3;
        @(posedge clk);
        wr_index <= REG_SPARE;
        wr_data  <= LEN_W'($urandom);
        @(posedge clk);
        wr_en <= 1'b0;
        link_len[int'(REG_LINK1)] = l1;
        link_len[int'(REG_LINK2)] = l2;
        link_len[int'(REG_LINK3)] = l3;
    endtask

    // Compare each returned pose with the oldest prediction.
    always @(negedge clk)
    begin
        pose_t want;
        if (rst_n && done)
        begin
            if (expected_poses.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d heading=%0d",
                         $time, pos_x, pos_y, heading);
                mismatches++;
            end
            else
            begin
                want = expected_poses.pop_front();
                if (pos_x !== want.pos_x)
                begin
                    $display("%0t: pos_x expected %0d, got %0d", $time, want.pos_x, pos_x);
                    mismatches++;
                end
                if (pos_y !== want.pos_y)
                begin
                    $display("%0t: pos_y expected %0d, got %0d", $time, want.pos_y, pos_y);
                    mismatches++;
                end
                if (heading !== want.heading)
                begin
                    $display("%0t: heading expected %0d, got %0d",
                             $time, want.heading, heading);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases per link setting.
    initial
    begin
        joint_row_t       row;
        logic [LEN_W-1:0] l1, l2, l3;
        bit               calm;
        int               k;
        int               ph;
        int               n;
        mismatches   = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        joint1_angle = '0;
        joint2_angle = '0;
        joint3_angle = '0;
        wr_en        = 1'b0;
        wr_index     = REG_LINK1;
        wr_data      = '0;
        link_len[0]  = 16'd19661;
        link_len[1]  = 16'd13107;
        link_len[2]  = 16'd9830;
        calm         = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset link lengths.
        for (k = 0; k < DIR_ROWS; k++)
        begin
            row = directed_row(k);
            send_request(row.j1, row.j2, row.j3, row.head_known, row.head);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    l1 = '0;
                    l2 = '0;
                    l3 = '0;
                end
                1:
                begin
                    l1 = '1;
                    l2 = '1;
                    l3 = '1;
                end
                2:
                begin
                    l1 = 16'd1;
                    l2 = 16'd32768;
                    l3 = '1;
                end
                5:
                begin
                    l1 = 16'd19661;
                    l2 = 16'd13107;
                    l3 = 16'd9830;
                end
                default:
                begin
                    l1 = LEN_W'($urandom);
                    l2 = LEN_W'($urandom);
                    l3 = LEN_W'($urandom);
                end
            endcase
            drain_results();
            set_links(l1, l2, l3);
            for (n = 0; n < PHASE_REQ; n++)
            begin
                if (n % 32 == 0)
                    calm = ($urandom_range(0, 2) == 0);
                // The closing stretch of the last phase runs back to back.
                if (!(ph == PHASES - 1 && n >= 25) && !calm && $urandom_range(0, 3) == 0)
                    rest($urandom_range(1, 17));
                send_request(pick_angle(), pick_angle(), pick_angle(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE)
            @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog against a hung pipeline.
    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
